>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker package
// Phase codes, status codes, word types and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int HdrDepth = 13;

   localparam logic [2:0] PH_SIG  = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_TYPE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC_ERR = 2'd1;
   localparam logic [1:0] ST_SIG_ERR = 2'd2;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;

   localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                          8'd13, 8'd10, 8'd26, 8'd10};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] chunk_type;
      logic [30:0] chunk_length;
      logic [30:0] image_width;
      logic [30:0] image_height;
      logic [7:0]  bit_depth;
      logic [7:0]  color_type;
      logic [7:0]  compression_method;
      logic [7:0]  filter_method;
      logic [7:0]  interlace_method;
   } rsp_word_type;

   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/pcc_if.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker channels
// Valid/ready channels for the byte stream and the chunk reports.
// ----------------------------------------------------------------------------
interface pcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, data_byte, file_start, input ready);
   modport sink   (input valid, data_byte, file_start, output ready);
endinterface

interface pcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] chunk_type;
   logic [30:0] chunk_length;
   logic [30:0] image_width;
   logic [30:0] image_height;
   logic [7:0]  bit_depth;
   logic [7:0]  color_type;
   logic [7:0]  compression_method;
   logic [7:0]  filter_method;
   logic [7:0]  interlace_method;

   modport source (output valid, status, chunk_type, chunk_length, image_width,
                   image_height, bit_depth, color_type, compression_method,
                   filter_method, interlace_method, input ready);
   modport sink   (input valid, status, chunk_type, chunk_length, image_width,
                   image_height, bit_depth, color_type, compression_method,
                   filter_method, interlace_method, output ready);
endinterface

>>> hw/rtl/pcc_req_reg.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker input register
// Holds one stream word; takes a new one whenever it is empty or the held word moves on.
// ----------------------------------------------------------------------------
module pcc_req_reg (
   input  logic                  clock,
   input  logic                  reset,
   pcc_req_if.sink               req_ch,
   input  logic                  advance,
   output logic                  hold_valid,
   output pcc_pkg::req_word_type hold_word
);

   logic                  valid_ff, valid_in;
   pcc_pkg::req_word_type word_ff, word_in;
   logic                  take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      word_in  = word_ff;
      if (take) begin
         word_in.data_byte  = req_ch.data_byte;
         word_in.file_start = req_ch.file_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign hold_valid = valid_ff;
   assign hold_word  = word_ff;

endmodule

>>> hw/rtl/pcc_parser.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker parser
// Signature check, chunk framing, running CRC and IHDR capture, one byte a cycle while advance is high.
// ----------------------------------------------------------------------------
module pcc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  pcc_pkg::req_word_type word,
   output pcc_pkg::step_type     step
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] scrc_ff, scrc_in;
   logic        halted_ff, halted_in;
   logic [7:0]  hdr_ff [pcc_pkg::HdrDepth];
   logic [7:0]  hdr_in [pcc_pkg::HdrDepth];

   logic [2:0]  phase_e;
   logic [31:0] cnt_e, crc_e, cnt_inc, crc_upd, scrc_shift;
   logic        halted_e;
   logic [7:0]  b;

   // a file start restarts parsing with this byte as signature byte 0
   assign b        = word.data_byte;
   assign phase_e  = word.file_start ? pcc_pkg::PH_SIG : phase_ff;
   assign cnt_e    = word.file_start ? 32'd0 : cnt_ff;
   assign crc_e    = word.file_start ? pcc_pkg::ALL_ONES : crc_ff;
   assign halted_e = word.file_start ? 1'b0 : halted_ff;
   assign cnt_inc  = cnt_e + 32'd1;
   assign crc_upd  = pcc_pkg::crc_byte(crc_e, b);
   assign scrc_shift = {scrc_ff[23:0], b};

   always_comb begin
      phase_in  = phase_e;
      cnt_in    = cnt_e;
      crc_in    = crc_e;
      len_in    = len_ff;
      type_in   = type_ff;
      scrc_in   = scrc_ff;
      halted_in = halted_e;
      hdr_in    = hdr_ff;
      step      = '0;

      if (!halted_e) begin
         case (phase_e)
            pcc_pkg::PH_SIG: begin
               if (b != pcc_pkg::PNG_SIG[cnt_e[2:0]]) begin
                  halted_in        = 1'b1;
                  step.emit        = 1'b1;
                  step.word.status = pcc_pkg::ST_SIG_ERR;
               end else if (cnt_e[2:0] == 3'd7) begin
                  phase_in = pcc_pkg::PH_LEN;
                  cnt_in   = 32'd0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            pcc_pkg::PH_LEN: begin
               len_in = {len_ff[23:0], b};
               if (cnt_e[1:0] == 2'd3) begin
                  phase_in = pcc_pkg::PH_TYPE;
                  cnt_in   = 32'd0;
                  crc_in   = pcc_pkg::ALL_ONES;
                  for (int i = 0; i < pcc_pkg::HdrDepth; i++) begin
                     hdr_in[i] = 8'd0;
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            pcc_pkg::PH_TYPE: begin
               type_in = {type_ff[23:0], b};
               crc_in  = crc_upd;
               if (cnt_e[1:0] == 2'd3) begin
                  phase_in = (len_ff == 32'd0) ? pcc_pkg::PH_CRC : pcc_pkg::PH_DATA;
                  cnt_in   = 32'd0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            pcc_pkg::PH_DATA: begin
               if (cnt_e < 32'(pcc_pkg::HdrDepth)) begin
                  hdr_in[cnt_e[3:0]] = b;
               end
               crc_in = crc_upd;
               if (cnt_inc == len_ff) begin
                  phase_in = pcc_pkg::PH_CRC;
                  cnt_in   = 32'd0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            pcc_pkg::PH_CRC: begin
               scrc_in = scrc_shift;
               if (cnt_e[1:0] == 2'd3) begin
                  step.emit              = 1'b1;
                  step.word.chunk_type   = type_ff;
                  step.word.chunk_length = len_ff[30:0];
                  if ((crc_e ^ pcc_pkg::ALL_ONES) == scrc_shift) begin
                     step.word.status = pcc_pkg::ST_OK;
                  end else begin
                     step.word.status = pcc_pkg::ST_CRC_ERR;
                     halted_in        = 1'b1;
                  end
                  if (type_ff == pcc_pkg::TYPE_IHDR) begin
                     step.word.image_width  = {hdr_ff[0][6:0], hdr_ff[1], hdr_ff[2],
                                               hdr_ff[3]};
                     step.word.image_height = {hdr_ff[4][6:0], hdr_ff[5], hdr_ff[6],
                                               hdr_ff[7]};
                     step.word.bit_depth          = hdr_ff[8];
                     step.word.color_type         = hdr_ff[9];
                     step.word.compression_method = hdr_ff[10];
                     step.word.filter_method      = hdr_ff[11];
                     step.word.interlace_method   = hdr_ff[12];
                  end
                  phase_in = pcc_pkg::PH_LEN;
                  cnt_in   = 32'd0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            default: begin
               halted_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pcc_pkg::PH_SIG;
         cnt_ff    <= 32'd0;
         crc_ff    <= pcc_pkg::ALL_ONES;
         halted_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         crc_ff    <= crc_in;
         halted_ff <= halted_in;
      end
      if (advance) begin
         len_ff  <= len_in;
         type_ff <= type_in;
         scrc_ff <= scrc_in;
         hdr_ff  <= hdr_in;
      end
   end

endmodule

>>> hw/rtl/pcc_rsp_reg.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker result register
// Holds one chunk report until the sink takes it.
// ----------------------------------------------------------------------------
module pcc_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pcc_pkg::rsp_word_type word,
   output logic                  slot_free,
   pcc_rsp_if.source             rsp_ch
);

   logic                  valid_ff, valid_in;
   pcc_pkg::rsp_word_type word_ff, word_in;

   assign slot_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);
      word_in  = load ? word : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_ch.valid              = valid_ff;
   assign rsp_ch.status             = word_ff.status;
   assign rsp_ch.chunk_type         = word_ff.chunk_type;
   assign rsp_ch.chunk_length       = word_ff.chunk_length;
   assign rsp_ch.image_width        = word_ff.image_width;
   assign rsp_ch.image_height       = word_ff.image_height;
   assign rsp_ch.bit_depth          = word_ff.bit_depth;
   assign rsp_ch.color_type         = word_ff.color_type;
   assign rsp_ch.compression_method = word_ff.compression_method;
   assign rsp_ch.filter_method      = word_ff.filter_method;
   assign rsp_ch.interlace_method   = word_ff.interlace_method;

endmodule

>>> hw/rtl/png_chunk_crc_checker.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker
// Takes a PNG file one byte per word, checks the signature, frames chunks,
// checks each chunk's CRC-32 and reports type, length, status and IHDR fields.
// ----------------------------------------------------------------------------
// Accepts one byte every cycle unless a reporting word must wait. The last CRC
// byte is taken into the input register and its report then loaded into the
// result register. The whole per-byte step (framing counters plus one byte-wide
// CRC-32 update) sits between those two registers. A word that yields no report
// moves on even while a report waits; a word that yields one waits only while
// the result register holds a report that is not taken in that cycle.
// After a signature or CRC error all words are dropped until file_start is set.
// ----------------------------------------------------------------------------
module png_chunk_crc_checker (
   input  logic      clock,
   input  logic      reset,
   pcc_req_if.sink   req_ch,
   pcc_rsp_if.source rsp_ch
);

   logic                  hold_valid;
   pcc_pkg::req_word_type hold_word;
   pcc_pkg::step_type     step;
   logic                  slot_free;
   logic                  advance;

   assign advance = hold_valid && (!step.emit || slot_free);

   pcc_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_word  (hold_word)
   );

   pcc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (hold_word),
      .step    (step)
   );

   pcc_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && step.emit),
      .word      (step.word),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> hw/rtl/pcc_checker.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker port checks
// Watches the report channel for holding and field consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_chunk_type,
   input logic [30:0] rsp_chunk_length,
   input logic [30:0] rsp_image_width,
   input logic [7:0]  rsp_bit_depth,
   input logic [7:0]  rsp_interlace_method
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_chunk_type)
      && $stable(rsp_chunk_length))
   `ASSERT_IMPLIES(a_status_code, clock, reset, rsp_valid,
      rsp_status == pcc_pkg::ST_OK || rsp_status == pcc_pkg::ST_CRC_ERR
      || rsp_status == pcc_pkg::ST_SIG_ERR)
   `ASSERT_IMPLIES(a_sig_err_empty, clock, reset,
      rsp_valid && rsp_status == pcc_pkg::ST_SIG_ERR,
      rsp_chunk_type == 32'd0 && rsp_chunk_length == 31'd0)
   `ASSERT_IMPLIES(a_non_ihdr_empty, clock, reset,
      rsp_valid && rsp_chunk_type != pcc_pkg::TYPE_IHDR,
      rsp_image_width == 31'd0 && rsp_bit_depth == 8'd0 && rsp_interlace_method == 8'd0)
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind png_chunk_crc_checker pcc_checker u_pcc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_status           (rsp_ch.status),
   .rsp_chunk_type       (rsp_ch.chunk_type),
   .rsp_chunk_length     (rsp_ch.chunk_length),
   .rsp_image_width      (rsp_ch.image_width),
   .rsp_bit_depth        (rsp_ch.bit_depth),
   .rsp_interlace_method (rsp_ch.interlace_method)
);

>>> tb/png_chunk_crc_checker_tb.sv
// ----------------------------------------------------------------------------
// PNG chunk CRC checker testbench
// Feeds byte streams built from PNG-style files. Many files are well formed:
// signature, then chunks (IHDR usually first) with random data and correct CRCs.
// The rest carry bad signatures, corrupted CRCs, cut-off chunks, oversized
// lengths and raw noise. A scoreboard tracks the framing state per byte and
// holds the chunk reports it expects. Each report from the block is compared
// field by field with the oldest expected one. Both channels stall at random.
// ----------------------------------------------------------------------------
module png_chunk_crc_checker_tb;

   localparam int ItemTarget  = 2000;
   localparam int CycleLimit  = 300000;
   localparam int DrainCycles = 8;

   // frames the byte stream and holds the chunk reports still to come
   class chunk_scoreboard;
      logic [2:0]   phase;
      logic [31:0]  count;
      logic [31:0]  crc;
      logic [31:0]  chunk_len;
      logic [31:0]  chunk_type;
      logic [31:0]  stored_crc;
      logic [7:0]   hdr [pcc_pkg::HdrDepth];
      bit           halted;
      pcc_pkg::rsp_word_type reports [$];
      int           errors;

      function new();
         errors = 0;
         restart();
      endfunction

      static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         repeat (8) r = r[0] ? ((r >> 1) ^ pcc_pkg::CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function void restart();
         phase      = pcc_pkg::PH_SIG;
         count      = '0;
         crc        = pcc_pkg::ALL_ONES;
         chunk_len  = '0;
         chunk_type = '0;
         stored_crc = '0;
         foreach (hdr[i]) hdr[i] = '0;
         halted     = 1'b0;
      endfunction

      function int pending();
         return reports.size();
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      // returns 1 when the word was not dropped by a halted parser
      function bit note_byte(logic [7:0] b, logic fs);
         pcc_pkg::rsp_word_type w;
         w = '0;
         if (fs) restart();
         if (halted) return 1'b0;
         case (phase)
            pcc_pkg::PH_SIG: begin
               if (b != pcc_pkg::PNG_SIG[count[2:0]]) begin
                  halted   = 1'b1;
                  w.status = pcc_pkg::ST_SIG_ERR;
                  reports.push_back(w);
               end else begin
                  count = count + 1;
                  if (count >= 8) begin
                     phase = pcc_pkg::PH_LEN;
                     count = '0;
                  end
               end
            end
            pcc_pkg::PH_LEN: begin
               chunk_len = {chunk_len[23:0], b};
               count     = count + 1;
               if (count >= 4) begin
                  phase = pcc_pkg::PH_TYPE;
                  count = '0;
                  crc   = pcc_pkg::ALL_ONES;
                  foreach (hdr[i]) hdr[i] = '0;
               end
            end
            pcc_pkg::PH_TYPE: begin
               chunk_type = {chunk_type[23:0], b};
               crc        = crc_update(crc, b);
               count      = count + 1;
               if (count >= 4) begin
                  phase = (chunk_len == 0) ? pcc_pkg::PH_CRC : pcc_pkg::PH_DATA;
                  count = '0;
               end
            end
            pcc_pkg::PH_DATA: begin
               if (count < pcc_pkg::HdrDepth) hdr[count[3:0]] = b;
               crc   = crc_update(crc, b);
               count = count + 1;
               if (count == chunk_len) begin
                  phase = pcc_pkg::PH_CRC;
                  count = '0;
               end
            end
            pcc_pkg::PH_CRC: begin
               stored_crc = {stored_crc[23:0], b};
               count      = count + 1;
               if (count >= 4) begin
                  w.status       = ((crc ^ pcc_pkg::ALL_ONES) == stored_crc) ?
                                   pcc_pkg::ST_OK : pcc_pkg::ST_CRC_ERR;
                  w.chunk_type   = chunk_type;
                  w.chunk_length = chunk_len[30:0];
                  if (chunk_type == pcc_pkg::TYPE_IHDR) begin
                     w.image_width        = {hdr[0][6:0], hdr[1], hdr[2], hdr[3]};
                     w.image_height       = {hdr[4][6:0], hdr[5], hdr[6], hdr[7]};
                     w.bit_depth          = hdr[8];
                     w.color_type         = hdr[9];
                     w.compression_method = hdr[10];
                     w.filter_method      = hdr[11];
                     w.interlace_method   = hdr[12];
                  end
                  if (w.status != pcc_pkg::ST_OK) halted = 1'b1;
                  phase = pcc_pkg::PH_LEN;
                  count = '0;
                  reports.push_back(w);
               end
            end
            default: halted = 1'b1;
         endcase
         return 1'b1;
      endfunction

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s: got %0h, expected %0h", name, got, want));
      endtask

      task check_report(pcc_pkg::rsp_word_type got);
         pcc_pkg::rsp_word_type want;
         if (reports.size() == 0) begin
            report($sformatf("unexpected report, status %0d type %0h", got.status,
                             got.chunk_type));
            return;
         end
         want = reports.pop_front();
         check_field("status", 32'(got.status), 32'(want.status));
         check_field("chunk_type", got.chunk_type, want.chunk_type);
         check_field("chunk_length", 32'(got.chunk_length), 32'(want.chunk_length));
         check_field("image_width", 32'(got.image_width), 32'(want.image_width));
         check_field("image_height", 32'(got.image_height), 32'(want.image_height));
         check_field("bit_depth", 32'(got.bit_depth), 32'(want.bit_depth));
         check_field("color_type", 32'(got.color_type), 32'(want.color_type));
         check_field("compression_method", 32'(got.compression_method),
                     32'(want.compression_method));
         check_field("filter_method", 32'(got.filter_method), 32'(want.filter_method));
         check_field("interlace_method", 32'(got.interlace_method),
                     32'(want.interlace_method));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   no_idle;
   int   live_count;
   int   cycle_count;

   logic [7:0]      file_bytes [$];
   chunk_scoreboard sb;

   pcc_req_if req_ch ();
   pcc_rsp_if rsp_ch ();

   png_chunk_crc_checker u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("png_chunk_crc_checker verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      pcc_pkg::rsp_word_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status             = rsp_ch.status;
         got.chunk_type         = rsp_ch.chunk_type;
         got.chunk_length       = rsp_ch.chunk_length;
         got.image_width        = rsp_ch.image_width;
         got.image_height       = rsp_ch.image_height;
         got.bit_depth          = rsp_ch.bit_depth;
         got.color_type         = rsp_ch.color_type;
         got.compression_method = rsp_ch.compression_method;
         got.filter_method      = rsp_ch.filter_method;
         got.interlace_method   = rsp_ch.interlace_method;
         sb.check_report(got);
      end
   end

   function automatic void push_be32(logic [31:0] v);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void push_sig();
      for (int i = 0; i < $size(pcc_pkg::PNG_SIG); i++)
         file_bytes.push_back(pcc_pkg::PNG_SIG[i]);
   endfunction

   // CRC after the four type bytes
   function automatic logic [31:0] type_crc(logic [31:0] ctype);
      logic [31:0] c;
      c = pcc_pkg::ALL_ONES;
      for (int i = 3; i >= 0; i--) c = chunk_scoreboard::crc_update(c, ctype[8*i +: 8]);
      return c;
   endfunction

   task automatic send_word(logic [7:0] d, logic fs);
      if (!no_idle && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= d;
      req_ch.file_start <= fs;
      do @(posedge clock); while (!req_ch.ready);
      if (sb.note_byte(d, fs)) live_count++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_word(file_bytes[i], i == 0);
   endtask

   // hold the stream until every report is out
   task automatic drain_pause();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic build_file();
      int unsigned kind;
      int unsigned n_chunks;
      int unsigned sel;
      int unsigned pos;
      logic [31:0] len;
      logic [31:0] ctype;
      logic [31:0] crc;
      logic [7:0]  b;
      bit          stop;
      file_bytes.delete();
      kind = $urandom_range(99);
      stop = 1'b0;
      if (kind < 5) begin
         // raw noise; the first word usually fails the signature
         repeat ($urandom_range(12, 1)) file_bytes.push_back(8'($urandom));
         return;
      end
      if (kind < 12) begin
         pos = $urandom_range(7);
         for (int i = 0; i < pos; i++) file_bytes.push_back(pcc_pkg::PNG_SIG[i]);
         file_bytes.push_back(pcc_pkg::PNG_SIG[pos] ^ 8'($urandom_range(255, 1)));
         repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
         return;
      end
      push_sig();
      n_chunks = $urandom_range(5, 1);
      for (int c = 0; c < n_chunks && !stop; c++) begin
         if ((c == 0 && $urandom_range(3) != 0) || $urandom_range(9) == 0)
            ctype = pcc_pkg::TYPE_IHDR;
         else
            ctype = $urandom;
         sel = $urandom_range(99);
         if (sel < 3)
            len = $urandom | 32'h0100_0000;
         else if (ctype == pcc_pkg::TYPE_IHDR)
            len = (sel < 60) ? 13 : (sel < 80) ? $urandom_range(12) : $urandom_range(24, 14);
         else
            len = (sel < 18) ? 0 : $urandom_range(16, 1);
         push_be32(len);
         push_be32(ctype);
         crc = type_crc(ctype);
         if (len > 32'd24) begin
            // oversized length: the chunk can never finish
            repeat ($urandom_range(6)) file_bytes.push_back(8'($urandom));
            stop = 1'b1;
         end else begin
            for (int i = 0; i < len; i++) begin
               b = 8'($urandom);
               file_bytes.push_back(b);
               crc = chunk_scoreboard::crc_update(crc, b);
            end
            crc = crc ^ pcc_pkg::ALL_ONES;
            sel = $urandom_range(99);
            if (sel < 12) begin
               crc  = crc ^ (32'd1 << $urandom_range(31));
               stop = 1'b1;
            end
            if (sel >= 96) begin
               // file cut inside the CRC field
               pos = $urandom_range(3);
               for (int i = 0; i < pos; i++) file_bytes.push_back(crc[31-8*i -: 8]);
               stop = 1'b1;
            end else begin
               push_be32(crc);
            end
         end
      end
      if (stop) repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
   endtask

   initial begin
      int file_idx;
      sb                = new();
      no_idle           = 1'b0;
      live_count        = 0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      req_ch.file_start = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bad first byte, a dropped word, then a minimal file with an empty IEND
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      file_bytes.delete();
      push_sig();
      push_be32(32'd0);
      push_be32(32'h4945_4E44);
      push_be32(type_crc(32'h4945_4E44) ^ pcc_pkg::ALL_ONES);
      send_file();

      file_idx = 0;
      while (live_count < ItemTarget) begin
         no_idle = (file_idx >= 8 && file_idx < 14);
         build_file();
         send_file();
         if (file_idx % 9 == 4) drain_pause();
         file_idx++;
      end
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.errors == 0)
         $display("png_chunk_crc_checker verification clean");
      else
         $display("png_chunk_crc_checker verification failed");
      $finish;
   end

endmodule
